@@ sv/ksa_pkg.sv @@
// ============================================================================
// ksa_pkg
// Shared types and constants for the shared-array multi-stack block.
// ============================================================================
package ksa_pkg;

    // Default sizing of the store and of the stack table.
    localparam int SLOTS_DEF  = 16;
    localparam int STACKS_DEF = 4;

    // Fixed widths of the request and response fields.
    localparam int DATA_W = 32;
    localparam int SID_W  = 2;
    localparam int STAT_W = 2;

    // Value returned by a pop from an empty stack.
    localparam logic [DATA_W-1:0] POP_EMPTY_VALUE = '1;

    // Request commands.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Response status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } state_t;

endpackage

@@ sv/ksa_ram.sv @@
// ============================================================================
// ksa_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ============================================================================
module ksa_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/k_stacks_shared_array_core.sv @@
// ============================================================================
// k_stacks_shared_array_core
// Several LIFO stacks sharing one slot store, with free slots on a linked list.
// ============================================================================
// Each request passes the read state and then the write state, which waits
// until the response register is free. A new request enters in idle or as the
// last one retires, after the slot link read and the link and list-head write-back.
// Reset: all stacks empty, free-list head at slot zero; the initial free chain
// is supplied by a fill watermark, so no clearing pass runs after reset.
module k_stacks_shared_array_core
    import ksa_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int STACKS = STACKS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     command,
    input  logic [SID_W-1:0]         stack_id,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] pop_value,
    output logic [STAT_W-1:0]        status
);

    // A pointer holds a slot index or the null value SLOTS.
    localparam int PTR_W = $clog2(SLOTS + 1);
    localparam int IDX_W = $clog2(SLOTS);
    // Only stacks reachable through the stack id port need a top register.
    localparam int MAX_IDS   = 1 << SID_W;
    localparam int NUM_TOPS  = (STACKS < MAX_IDS) ? STACKS : MAX_IDS;
    localparam int TOP_IDX_W = (NUM_TOPS > 1) ? $clog2(NUM_TOPS) : 1;
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOTS);

    state_t state_reg, state_next;

    // Captured request.
    logic              cmd_reg;
    logic [SID_W-1:0]  sid_reg;
    logic [DATA_W-1:0] val_reg;

    // Slot chosen in the read cycle and whether the request is rejected.
    logic [PTR_W-1:0] slot_reg;
    logic             err_reg;

    // List heads.
    logic [PTR_W-1:0] free_head_reg;
    logic [PTR_W-1:0] top_reg [NUM_TOPS];

    // Slots at or above the watermark have never had their link written, so
    // their link is still the reset chain value (index plus one, or null for
    // the last slot). The free list hands out fresh slots in index order.
    logic [PTR_W-1:0] wm_reg;

    // Response register.
    logic              out_valid_reg;
    logic [DATA_W-1:0] pop_value_reg;
    logic [STAT_W-1:0] status_reg;

    logic                 accept;
    logic                 out_free;
    logic                 finish;
    logic                 sid_ok;
    logic [TOP_IDX_W-1:0] top_idx;
    logic [PTR_W-1:0]     top_sel;
    logic [PTR_W-1:0]     slot_pick;
    logic                 err_next;
    logic                 rd_en;
    logic                 wr_en;
    logic [PTR_W-1:0]     link_rd;
    logic [PTR_W-1:0]     link_eff;
    logic [PTR_W-1:0]     link_wr;
    logic [DATA_W-1:0]    data_rd;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Stack ids beyond the configured count behave like a full store on push
    // and an empty stack on pop.
    assign sid_ok  = {{(32 - SID_W){1'b0}}, sid_reg} < 32'(STACKS);
    assign top_idx = TOP_IDX_W'(sid_reg);
    assign top_sel = top_reg[top_idx];

    // A push takes the free-list head; a pop takes the stack's top.
    assign slot_pick = (cmd_reg == CMD_PUSH) ? free_head_reg : top_sel;
    assign err_next  = !sid_ok || (slot_pick >= NULL_PTR);

    // Untouched slots supply the reset chain instead of the memory contents.
    assign link_eff = (slot_reg >= wm_reg) ? (slot_reg + PTR_W'(1)) : link_rd;

    // A push links the new slot in front of the stack's top; a pop returns the
    // slot to the front of the free list.
    assign link_wr = (cmd_reg == CMD_PUSH) ? top_sel : free_head_reg;

    // ------------------------------------------------------------------------
    // Sequencer: capture, read the slot link and data, then write back.
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = accept ? ST_READ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        finish   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_READ:
            begin
                rd_en = 1'b1;
            end
            ST_WRITE:
            begin
                // The next request enters while this one retires into the
                // response register.
                in_ready = out_free;
                finish   = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign wr_en = finish && !err_reg;

    // ------------------------------------------------------------------------
    // Slot memories: data and link, read in the read cycle, written at retire.
    // ------------------------------------------------------------------------
    ksa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (wr_en && (cmd_reg == CMD_PUSH)),
        .wr_addr (slot_reg[IDX_W-1:0]),
        .wr_data (val_reg),
        .rd_en   (rd_en),
        .rd_addr (slot_pick[IDX_W-1:0]),
        .rd_data (data_rd)
    );

    ksa_ram #(
        .WIDTH (PTR_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg[IDX_W-1:0]),
        .wr_data (link_wr),
        .rd_en   (rd_en),
        .rd_addr (slot_pick[IDX_W-1:0]),
        .rd_data (link_rd)
    );

    // ------------------------------------------------------------------------
    // Control state.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            err_reg       <= 1'b0;
            free_head_reg <= '0;
            wm_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TOPS; i++)
            begin
                top_reg[i] <= NULL_PTR;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (rd_en)
            begin
                err_reg <= err_next;
            end
            if (wr_en)
            begin
                if (cmd_reg == CMD_PUSH)
                begin
                    free_head_reg    <= link_eff;
                    top_reg[top_idx] <= slot_reg;
                    if (slot_reg == wm_reg)
                    begin
                        wm_reg <= wm_reg + PTR_W'(1);
                    end
                end
                else
                begin
                    top_reg[top_idx] <= link_eff;
                    free_head_reg    <= slot_reg;
                end
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request capture, chosen slot and response payload.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            sid_reg <= stack_id;
            val_reg <= push_value;
        end
        if (rd_en)
        begin
            slot_reg <= slot_pick;
        end
        if (finish)
        begin
            if (cmd_reg == CMD_PUSH)
            begin
                pop_value_reg <= '0;
                status_reg    <= err_reg ? STAT_OVERFLOW : STAT_OK;
            end
            else
            begin
                pop_value_reg <= err_reg ? POP_EMPTY_VALUE : data_rd;
                status_reg    <= err_reg ? STAT_UNDERFLOW : STAT_OK;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pop_value = pop_value_reg;
    assign status    = status_reg;

endmodule

@@ tb/tb_top.sv @@
// ============================================================================
// tb_top
// Self-checking bench for k_stacks_shared_array_core: directed and random
// push/pop requests, checked against a cycle-free model of the stacks.
// ============================================================================
// The bench sends push and pop requests through the request channel and
// collects one response per request on the response channel. A small class
// keeps its own copy of the slot store, the link table, the stack tops and
// the free-list head. It computes the expected pop value and status for every
// accepted request, and it compares each response with the oldest one still
// waiting. Both channels idle at random, with calm stretches in between.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ksa_pkg::*;

    localparam int NSLOTS  = SLOTS_DEF;
    localparam int NSTACKS = STACKS_DEF;

    // One expected response.
    typedef struct {
        logic [DATA_W-1:0] value;
        logic [STAT_W-1:0] stat;
    } stack_resp_t;

    // Model of the shared store together with the queue of responses it
    // predicts. A pointer at or above NSLOTS means "no slot".
    class stack_scoreboard;
        logic [DATA_W-1:0] slot_val [NSLOTS];
        int                slot_next [NSLOTS];
        int                top_of [NSTACKS];
        int                free_ptr;
        stack_resp_t       awaited [$];
        int                errors;

        function new();
            for (int i = 0; i < NSLOTS; i++)
            begin
                slot_val[i]  = '0;
                slot_next[i] = i + 1;
            end
            for (int s = 0; s < NSTACKS; s++)
            begin
                top_of[s] = NSLOTS;
            end
            free_ptr = 0;
            errors   = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function int depth(int sid);
            int n;
            int p;
            n = 0;
            p = top_of[sid];
            while (p < NSLOTS && n <= NSLOTS)
            begin
                n++;
                p = slot_next[p];
            end
            return n;
        endfunction

        // Apply one accepted request to the model and queue its response.
        function void note_request(logic cmd, logic [SID_W-1:0] sid,
                                   logic [DATA_W-1:0] val);
            stack_resp_t r;
            int          slot;
            if (cmd == CMD_PUSH)
            begin
                if (int'(sid) >= NSTACKS || free_ptr >= NSLOTS)
                begin
                    r.value = '0;
                    r.stat  = STAT_OVERFLOW;
                end
                else
                begin
                    slot            = free_ptr;
                    free_ptr        = slot_next[slot];
                    slot_next[slot] = top_of[sid];
                    top_of[sid]     = slot;
                    slot_val[slot]  = val;
                    r.value = '0;
                    r.stat  = STAT_OK;
                end
            end
            else
            begin
                if (int'(sid) >= NSTACKS || top_of[sid] >= NSLOTS)
                begin
                    r.value = POP_EMPTY_VALUE;
                    r.stat  = STAT_UNDERFLOW;
                end
                else
                begin
                    slot            = top_of[sid];
                    top_of[sid]     = slot_next[slot];
                    slot_next[slot] = free_ptr;
                    free_ptr        = slot;
                    r.value = slot_val[slot];
                    r.stat  = STAT_OK;
                end
            end
            awaited.push_back(r);
        endfunction

        task report(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            if (errors < 100)
            begin
                $display("%0t ns: mismatch on %s: expected %h, got %h",
                         $realtime, what, want, got);
            end
            errors++;
        endtask

        task check_response(logic [DATA_W-1:0] value, logic [STAT_W-1:0] stat);
            stack_resp_t r;
            if (awaited.size() == 0)
            begin
                report("unexpected response", '0, value);
            end
            else
            begin
                r = awaited.pop_front();
                if (value !== r.value)
                begin
                    report("pop_value", r.value, value);
                end
                if (stat !== r.stat)
                begin
                    report("status", DATA_W'(r.stat), DATA_W'(stat));
                end
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs. Every input holds a known value at time 0.
    // ------------------------------------------------------------------------
    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    logic                     command    = CMD_PUSH;
    logic [SID_W-1:0]         stack_id   = '0;
    logic signed [DATA_W-1:0] push_value = '0;
    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic signed [DATA_W-1:0] pop_value;
    logic [STAT_W-1:0]        status;

    // When set, neither side inserts gaps or stalls.
    bit calm = 1'b0;

    stack_scoreboard sb = new();

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    k_stacks_shared_array_core #(
        .SLOTS  (NSLOTS),
        .STACKS (NSTACKS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .stack_id   (stack_id),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pop_value  (pop_value),
        .status     (status)
    );

    // Gap length: mostly none, often short, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Monitors. Both sample at the rising edge, where the handshake values are
    // those that decided acceptance. A response never shares an edge with its
    // own request, since the block answers only after its read and write states.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            sb.note_request(command, stack_id, push_value);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_response(pop_value, status);
        end
    end

    // Response side back-pressure: stall for a random number of cycles,
    // then accept, with a fresh stall drawn after each ready cycle.
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready  <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Request driver. The payload is set together with valid and held until
    // the request is taken. Valid is only lowered when a gap follows, so a
    // back-to-back request never gets two assignments in one time step.
    // ------------------------------------------------------------------------
    task automatic send_request(logic cmd, logic [SID_W-1:0] sid,
                                logic [DATA_W-1:0] val);
        in_valid   <= 1'b1;
        command    <= cmd;
        stack_id   <= sid;
        push_value <= val;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Send one request followed by a random gap.
    task automatic issue(logic cmd, logic [SID_W-1:0] sid, logic [DATA_W-1:0] val);
        send_request(cmd, sid, val);
        pause_sender(pick_gap());
    endtask

    // Push value with a bias toward the corners of the 32-bit range.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [DATA_W-1:0] corner [6];
        int                push_pct;
        int                fav;
        logic [SID_W-1:0]  sid;

        corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Popping every stack while all are empty gives
        // underflows. Sixteen pushes spread over all stacks fill the store,
        // with the corner values among them, so the next push overflows.
        // A pop from each stack then returns its most recent push.
        for (int s = 0; s < NSTACKS; s++)
        begin
            issue(CMD_POP, SID_W'(s), $urandom);
        end
        for (int i = 0; i < NSLOTS; i++)
        begin
            issue(CMD_PUSH, SID_W'(i % NSTACKS), (i < 6) ? corner[i] : $urandom);
        end
        issue(CMD_PUSH, SID_W'(2), 32'h1234_5678);
        for (int s = NSTACKS - 1; s >= 0; s--)
        begin
            issue(CMD_POP, SID_W'(s), $urandom);
        end

        // Random part, in chunks of 50 requests. Each chunk has its own
        // push ratio, so the store at times fills to overflow and at times drains
        // to underflow, and a favored stack so that single stacks grow deep.
        // Some chunks run without gaps on either side.
        for (int c = 0; c < 20; c++)
        begin
            case ($urandom_range(0, 5))
                0: push_pct = 92;
                1: push_pct = 8;
                default: push_pct = $urandom_range(25, 75);
            endcase
            fav  = $urandom_range(0, NSTACKS - 1);
            calm = ($urandom_range(0, 3) == 0);

            // Halfway through, hold off until every response is back.
            if (c == 10)
            begin
                pause_sender(1);
                while (sb.pending() != 0)
                begin
                    @(posedge clk);
                end
            end

            for (int i = 0; i < 50; i++)
            begin
                sid = ($urandom_range(0, 1) == 0) ? SID_W'(fav)
                                                  : SID_W'($urandom_range(0, NSTACKS - 1));
                if ($urandom_range(0, 99) < push_pct)
                begin
                    issue(CMD_PUSH, sid, pick_value());
                end
                else
                begin
                    issue(CMD_POP, sid, $urandom);
                end
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;
        // Waiting for a clock edge lets the monitor record the last accepted request first.
        @(posedge clk);

        // Drain: wait for every response, then wait on a while longer so that a
        // stray extra response would still be caught.
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of about 1000 requests.
    initial
    begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/ksa_pkg.sv
sv/ksa_ram.sv
sv/k_stacks_shared_array_core.sv
tb/tb_top.sv
